// ----- hdl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition never holds.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ----- hdl/egbw_pkg.sv -----
// Shared types and constants of the exp-Golomb bitstream writer.
package egbw_pkg;

    localparam int VALUE_WIDTH_DEF = 32;

    localparam int CODE_W  = 33;
    localparam int LEN_W   = 7;
    localparam int ACC_W   = 72;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = 3;

    localparam logic [2:0] OP_FIXED = 3'd0;
    localparam logic [2:0] OP_UE    = 3'd1;
    localparam logic [2:0] OP_SE    = 3'd2;
    localparam logic [2:0] OP_FLUSH = 3'd3;
    localparam logic [2:0] OP_NAL   = 3'd4;

    typedef struct packed {
        logic [CODE_W-1:0] data;
        logic [LEN_W-1:0]  nbits;
        logic              flush;
        logic              nal;
    } egbw_entry_t;

    typedef struct packed {
        logic full;
        logic valid;
    } egbw_qstat_t;

endpackage

// ----- hdl/exp_golomb_bitstream_writer.sv -----
// Top level of the H.264 exp-Golomb bitstream writer.
// Items pass through the front-end input register, the queue and the packer to the output register.
// The packer takes a new item from the queue only after it has given every result byte
// of the last one, and a stalled output holds it.
// Reset clears the partial byte (bit position back to the MSB), queue and valids.
`include "assert_macros.svh"

module exp_golomb_bitstream_writer #(
    parameter int VALUE_WIDTH = egbw_pkg::VALUE_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         opcode,
    input  logic [31:0]        unsigned_value,
    input  logic signed [31:0] signed_value,
    input  logic [5:0]         bit_count,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         out_byte,
    output logic               is_boundary,
    output logic               last
);
    import egbw_pkg::*;

    egbw_qstat_t q_status;
    egbw_entry_t push_entry;
    egbw_entry_t head;
    logic        push;
    logic        pop;

    egbw_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .unsigned_value (unsigned_value),
        .signed_value   (signed_value),
        .bit_count      (bit_count),
        .q_status       (q_status),
        .push           (push),
        .push_entry     (push_entry)
    );

    egbw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_status   (q_status)
    );

    egbw_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_status    (q_status),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .is_boundary (is_boundary),
        .last        (last)
    );

    `ASSERT_IMPLIES(a_bnd_zero_last, clk, rst_n, out_valid && is_boundary, out_byte == 8'd0 && last, "boundary item must be a zero final byte")
    `ASSERT_IMPLIES(a_stall_full, clk, rst_n, in_stall, q_status.full, "input stalled while queue has room")
    `ASSERT_NEVER(a_pop_empty, clk, rst_n, pop && !q_status.valid, "packer popped an empty queue")

endmodule

// ----- hdl/egbw_front.sv -----
// Front end: input register, code forming and reduction of each item to a bit write.
module egbw_front #(
    parameter int VALUE_WIDTH = egbw_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [2:0]             opcode,
    input  logic [31:0]            unsigned_value,
    input  logic signed [31:0]     signed_value,
    input  logic [5:0]             bit_count,
    input  egbw_pkg::egbw_qstat_t  q_status,
    output logic                   push,
    output egbw_pkg::egbw_entry_t  push_entry
);
    import egbw_pkg::*;

    localparam int UW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;

    logic              s1_v_reg, s1_v_next;
    logic [2:0]        op_reg;
    logic [CODE_W-1:0] code_reg;
    logic [UW-1:0]     uval_reg;
    logic [5:0]        cnt_reg;

    logic              accept;
    logic [31:0]       sraw;
    logic [31:0]       mag;
    logic [CODE_W-1:0] code_in;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  golomb_n;
    logic [CODE_W-1:0] uval_ext;
    logic [CODE_W-1:0] fixed_data;

    assign in_stall = s1_v_reg && q_status.full;
    assign accept   = in_valid && !in_stall;
    assign push     = s1_v_reg && !q_status.full;

    assign sraw = signed_value;
    assign mag  = (~sraw) + 32'd1;

    always_comb
    begin
        case (opcode)
            OP_UE:
            begin
                code_in = CODE_W'(unsigned_value[UW-1:0]) + CODE_W'(1);
            end
            OP_SE:
            begin
                if (sraw == 32'd0)
                begin
                    code_in = CODE_W'(1);
                end
                else if (sraw[31])
                begin
                    code_in = {mag, 1'b1};
                end
                else
                begin
                    code_in = {sraw, 1'b0};
                end
            end
            default:
            begin
                code_in = '0;
            end
        endcase
    end

    always_comb
    begin
        s1_v_next = s1_v_reg;
        if (accept)
        begin
            s1_v_next = 1'b1;
        end
        else if (push)
        begin
            s1_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= s1_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= opcode;
            code_reg <= code_in;
            uval_reg <= unsigned_value[UW-1:0];
            cnt_reg  <= bit_count;
        end
    end

    always_comb
    begin
        len = '0;
        for (int i = 0; i < CODE_W; i++)
        begin
            if (code_reg[i])
            begin
                len = LEN_W'(i + 1);
            end
        end
    end

    assign golomb_n = (len << 1) - LEN_W'(1);
    assign uval_ext = CODE_W'(uval_reg);

    always_comb
    begin
        for (int i = 0; i < CODE_W; i++)
        begin
            fixed_data[i] = uval_ext[i] && (i < int'(cnt_reg));
        end
    end

    always_comb
    begin
        push_entry = '0;
        case (op_reg)
            OP_FIXED:
            begin
                push_entry.data  = fixed_data;
                push_entry.nbits = {1'b0, cnt_reg};
            end
            OP_UE, OP_SE:
            begin
                push_entry.data  = code_reg;
                push_entry.nbits = golomb_n;
            end
            OP_FLUSH:
            begin
                push_entry.flush = 1'b1;
            end
            OP_NAL:
            begin
                push_entry.flush = 1'b1;
                push_entry.nal   = 1'b1;
            end
            default:
            begin
                push_entry = '0;
            end
        endcase
    end

endmodule

// ----- hdl/egbw_queue.sv -----
// Short FIFO of bit-write entries between the front end and the packer.
module egbw_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  egbw_pkg::egbw_entry_t  push_entry,
    input  logic                   pop,
    output egbw_pkg::egbw_entry_t  head,
    output egbw_pkg::egbw_qstat_t  q_status
);
    import egbw_pkg::*;

    egbw_entry_t         slot_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign head           = slot_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == QCNT_W'(QDEPTH));
    assign q_status.valid = (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- hdl/egbw_back.sv -----
// Back end: bit accumulator holding the partial byte, byte emission and output register.
module egbw_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  egbw_pkg::egbw_entry_t  head,
    input  egbw_pkg::egbw_qstat_t  q_status,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [7:0]             out_byte,
    output logic                   is_boundary,
    output logic                   last
);
    import egbw_pkg::*;

    logic              act_reg, act_next;
    logic              flush_reg, flush_next;
    logic              nal_reg, nal_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [LEN_W-1:0]  fill_reg, fill_next;
    logic              out_v_reg, out_v_next;
    logic [7:0]        byte_reg;
    logic              bnd_reg;
    logic              last_reg;

    logic              has_full, pad, bnd, any_out, work, done, out_free, emit;
    logic              last_full, last_emit;
    logic [LEN_W-1:0]  rem;
    logic [LEN_W-1:0]  shift;
    logic [ACC_W-1:0]  aligned;

    assign has_full  = (fill_reg >= LEN_W'(8));
    assign rem       = fill_reg - LEN_W'(8);
    assign pad       = !has_full && flush_reg && (fill_reg != '0);
    assign bnd       = !has_full && !pad && nal_reg;
    assign any_out   = has_full || pad || bnd;
    assign work      = act_reg && any_out;
    assign done      = act_reg && !any_out;
    assign out_free  = !out_v_reg || !out_stall;
    assign emit      = work && out_free;
    assign pop       = q_status.valid && (!act_reg || done);

    assign last_full = (rem < LEN_W'(8)) && !(flush_reg && (rem != '0)) && !nal_reg;
    assign last_emit = has_full ? last_full : (pad ? !nal_reg : 1'b1);

    assign shift     = LEN_W'(ACC_W) - fill_reg - head.nbits;
    assign aligned   = ACC_W'(head.data) << shift;

    always_comb
    begin
        act_next   = act_reg;
        flush_next = flush_reg;
        nal_next   = nal_reg;
        acc_next   = acc_reg;
        fill_next  = fill_reg;
        if (pop)
        begin
            acc_next   = acc_reg | aligned;
            fill_next  = fill_reg + head.nbits;
            act_next   = 1'b1;
            flush_next = head.flush;
            nal_next   = head.nal;
        end
        else if (done)
        begin
            act_next = 1'b0;
        end
        else if (emit)
        begin
            if (has_full)
            begin
                acc_next  = acc_reg << 8;
                fill_next = rem;
            end
            else if (pad)
            begin
                acc_next   = '0;
                fill_next  = '0;
                flush_next = 1'b0;
            end
            else
            begin
                nal_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        out_v_next = out_v_reg;
        if (emit)
        begin
            out_v_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg   <= 1'b0;
            flush_reg <= 1'b0;
            nal_reg   <= 1'b0;
            acc_reg   <= '0;
            fill_reg  <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            act_reg   <= act_next;
            flush_reg <= flush_next;
            nal_reg   <= nal_next;
            acc_reg   <= acc_next;
            fill_reg  <= fill_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            byte_reg <= bnd ? 8'd0 : acc_reg[ACC_W-1 -: 8];
            bnd_reg  <= bnd;
            last_reg <= last_emit;
        end
    end

    assign out_valid   = out_v_reg;
    assign out_byte    = byte_reg;
    assign is_boundary = bnd_reg;
    assign last        = last_reg;

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the exp-Golomb bitstream writer, with its own byte packer.
`timescale 1ns / 100ps

module tb_top;
    import egbw_pkg::*;

    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam int MAX_BYTES = 10;
    localparam int RANDOM_ITEMS = 300;
    localparam int CALM_TAIL = 30;
    localparam int LONG_HOLD_AT = 100;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int TAIL_CYCLES = 30;
    localparam int CYCLE_LIMIT = 300000;

    typedef struct {
        logic [2:0]  op;
        logic [31:0] uval;
        logic [31:0] sval;
        logic [5:0]  nbits;
        bit          hold_for_drain;
    } element_t;

    typedef struct packed {
        logic [7:0] data;
        logic       boundary;
        logic       fin;
    } stream_byte_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [2:0]         opcode = OP_FIXED;
    logic [31:0]        unsigned_value = '0;
    logic signed [31:0] signed_value = '0;
    logic [5:0]         bit_count = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [7:0]         out_byte;
    logic               is_boundary;
    logic               last;

    element_t     element_q[$];
    element_t     cur;
    stream_byte_t byte_queue[$];
    stream_byte_t item_bytes[$];
    logic [7:0]   pack_byte = '0;
    logic [2:0]   pack_pos = 3'd7;

    int unsigned accepted_count = 0;
    int unsigned predicted_count = 0;
    int unsigned checked_count = 0;
    int unsigned total_items = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    bit          long_hold_done = 1'b0;
    logic        calm = 1'b0;

    exp_golomb_bitstream_writer DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .unsigned_value (unsigned_value),
        .signed_value   (signed_value),
        .bit_count      (bit_count),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .is_boundary    (is_boundary),
        .last           (last)
    );

    function automatic void emit(input logic [7:0] b, input logic boundary);
        stream_byte_t e;
        e.data = b;
        e.boundary = boundary;
        e.fin = 1'b0;
        if (item_bytes.size() < MAX_BYTES)
            item_bytes.push_back(e);
    endfunction

    function automatic void shift_in(input logic [63:0] data, input int n);
        for (int i = n - 1; i >= 0; i--)
        begin
            pack_byte[pack_pos] = data[i];
            if (pack_pos == 3'd0)
            begin
                emit(pack_byte, 1'b0);
                pack_byte = '0;
                pack_pos = 3'd7;
            end
            else
                pack_pos = pack_pos - 3'd1;
        end
    endfunction

    function automatic void write_golomb(input logic [63:0] code);
        int len;
        len = 0;
        for (int i = 0; i < 64; i++)
            if (code[i])
                len = i + 1;
        if (len == 0)
            len = 1;
        shift_in(64'd0, len - 1);
        shift_in(code, len);
    endfunction

    function automatic void flush_partial();
        if (pack_pos != 3'd7)
        begin
            emit(pack_byte, 1'b0);
            pack_byte = '0;
            pack_pos = 3'd7;
        end
    endfunction

    function automatic void encode_element(input element_t el);
        logic [31:0] mag;
        item_bytes.delete();
        case (el.op)
            OP_FIXED: shift_in({32'd0, el.uval}, int'(el.nbits));
            OP_UE:    write_golomb({32'd0, el.uval} + 64'd1);
            OP_SE:
            begin
                if (el.sval == 32'd0)
                    write_golomb(64'd1);
                else if (el.sval[31])
                begin
                    mag = ~el.sval + 32'd1;
                    write_golomb({31'd0, mag, 1'b1});
                end
                else
                    write_golomb({31'd0, el.sval, 1'b0});
            end
            OP_FLUSH: flush_partial();
            OP_NAL:
            begin
                flush_partial();
                emit(8'd0, 1'b1);
            end
            default: ;
        endcase
        if (item_bytes.size() > 0)
            item_bytes[item_bytes.size() - 1].fin = 1'b1;
    endfunction

    function automatic void queue_element(input logic [2:0] op, input logic [31:0] uval,
                                          input logic [31:0] sval, input logic [5:0] nbits);
        element_t el;
        el.op = op;
        el.uval = uval;
        el.sval = sval;
        el.nbits = nbits;
        el.hold_for_drain = 1'b0;
        element_q.push_back(el);
    endfunction

    function automatic logic [31:0] pick_signed();
        logic [31:0] mag;
        if ($urandom_range(0, 49) == 0)
            return 32'h8000_0000;
        mag = $urandom >> $urandom_range(1, 31);
        return $urandom_range(0, 1) ? mag : -mag;
    endfunction

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("exp_golomb_bitstream_writer verification failed");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : driver
        logic took;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            took = in_valid && !in_stall;
            if (took)
            begin
                encode_element(cur);
                foreach (item_bytes[i])
                    byte_queue.push_back(item_bytes[i]);
                predicted_count <= predicted_count + item_bytes.size();
                accepted_count <= accepted_count + 1;
            end
            if (!in_valid || took)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (element_q.size() == 0)
                    in_valid <= 1'b0;
                else if (element_q[0].hold_for_drain &&
                         (took || checked_count != predicted_count))
                    in_valid <= 1'b0;
                else
                begin
                    cur = element_q.pop_front();
                    opcode <= cur.op;
                    unsigned_value <= cur.uval;
                    signed_value <= cur.sval;
                    bit_count <= cur.nbits;
                    in_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 3) == 0)
                        gap_left = $urandom_range(1, 5);
                end
            end
            calm <= (element_q.size() <= CALM_TAIL);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (stall_left == 0 && !long_hold_done && accepted_count >= LONG_HOLD_AT)
            begin
                long_hold_done = 1'b1;
                stall_left = LONG_HOLD_CYCLES;
            end
            else if (stall_left == 0 && !calm && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 5);
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : monitor
        stream_byte_t want;
        if (!rst_n)
            checked_count <= 0;
        else if (out_valid && !out_stall)
        begin
            if (checked_count >= predicted_count)
            begin
                if (mismatches < 10)
                    $display("unexpected byte %02h boundary %0b last %0b",
                             out_byte, is_boundary, last);
                mismatches++;
            end
            else
            begin
                want = byte_queue.pop_front();
                if (want !== {out_byte, is_boundary, last})
                begin
                    if (mismatches < 10)
                        $display("mismatch: expected %02h/%0b/%0b got %02h/%0b/%0b",
                                 want.data, want.boundary, want.fin,
                                 out_byte, is_boundary, last);
                    mismatches++;
                end
                checked_count <= checked_count + 1;
            end
        end
    end

    initial
    begin : stimulus
        int r;
        logic [2:0] op;
        queue_element(OP_FIXED, $urandom, $urandom, 6'd0);
        queue_element(OP_FLUSH, $urandom, $urandom, 6'($urandom));
        queue_element(OP_FIXED, 32'd1, $urandom, 6'd1);
        queue_element(OP_FIXED, 32'hFFFF_FFFF, $urandom, 6'd32);
        queue_element(OP_FIXED, 32'hFFFF_FFFF, $urandom, 6'd63);
        queue_element(OP_FIXED, 32'hA5A5_5A5A, $urandom, 6'd33);
        queue_element(OP_UE, 32'd0, $urandom, 6'($urandom));
        queue_element(OP_UE, 32'hFFFF_FFFF, $urandom, 6'($urandom));
        queue_element(OP_UE, 32'hFFFF_FFFE, $urandom, 6'($urandom));
        queue_element(OP_SE, $urandom, 32'd0, 6'($urandom));
        queue_element(OP_SE, $urandom, 32'd1, 6'($urandom));
        queue_element(OP_SE, $urandom, 32'hFFFF_FFFF, 6'($urandom));
        queue_element(OP_SE, $urandom, 32'h7FFF_FFFF, 6'($urandom));
        queue_element(OP_SE, $urandom, 32'h8000_0001, 6'($urandom));
        queue_element(OP_SE, $urandom, 32'h8000_0000, 6'($urandom));
        queue_element(OP_FLUSH, $urandom, $urandom, 6'($urandom));
        queue_element(OP_NAL, $urandom, $urandom, 6'($urandom));
        queue_element(OP_FIXED, 32'd5, $urandom, 6'd3);
        queue_element(OP_NAL, $urandom, $urandom, 6'($urandom));
        for (int k = OP_SPARE_LO; k <= OP_SPARE_HI; k++)
            queue_element(k[2:0], $urandom, $urandom, 6'($urandom));
        queue_element(OP_FIXED, 32'h0000_0000, $urandom, 6'd63);
        queue_element(OP_FLUSH, $urandom, $urandom, 6'($urandom));

        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
                op = OP_FIXED;
            else if (r < 60)
                op = OP_UE;
            else if (r < 85)
                op = OP_SE;
            else if (r < 91)
                op = OP_FLUSH;
            else if (r < 96)
                op = OP_NAL;
            else
                op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            queue_element(op, $urandom >> $urandom_range(0, 31), pick_signed(),
                          6'(($urandom_range(0, 9) == 0) ? $urandom_range(33, 63)
                                                         : $urandom_range(0, 32)));
            if (k == 50 || k == 200)
                element_q[element_q.size() - 1].hold_for_drain = 1'b1;
        end
        total_items = element_q.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_count != total_items)
            @(posedge clk);
        while (checked_count != predicted_count)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && checked_count == predicted_count)
            $display("exp_golomb_bitstream_writer verification clean");
        else
            $display("exp_golomb_bitstream_writer verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/egbw_pkg.sv
hdl/egbw_front.sv
hdl/egbw_queue.sv
hdl/egbw_back.sv
hdl/exp_golomb_bitstream_writer.sv
sim/tb_top.sv
